/* hdl/tlfa_pkg.sv */
// Shared types and constants for the timed lowest-free unit allocator.
package tlfa_pkg;

    // Widths of the word fields
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned SUM_W   = 12;
    localparam int unsigned MASK_W  = 64;

    // Width of the count that travels along the cell row; holds up to 511 units
    localparam int unsigned CNT_W   = 9;

    // Register reset value of units in service
    localparam logic [COUNT_W-1:0] UNITS_RESET = 7'd64;

    typedef struct packed {
        logic [TIME_W-1:0]  request_time;
        logic [COUNT_W-1:0] unit_count;
        logic [HOLD_W-1:0]  hold_time;
    } t_in_word;

    typedef struct packed {
        logic               granted;
        logic [SUM_W-1:0]   id_sum;
        logic [MASK_W-1:0]  granted_mask;
    } t_out_word;

    // Wave handed from cell to cell: a scan pulse counts free units, a fill
    // pulse carries the units still wanted and the running id sum
    typedef struct packed {
        logic               scan;
        logic               fill;
        logic [CNT_W-1:0]   cnt;
        logic [SUM_W-1:0]   sum;
    } t_wave;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH_SCAN,
        ST_SCAN,
        ST_LAUNCH_FILL,
        ST_FILL,
        ST_DONE
    } t_state;

endpackage

/* hdl/timed_lowest_free_unit_allocator_unit.sv */
// Top level: request control and the row of unit cells.
//
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+---------------------------
//  request  | in        | i_in_valid / o_in_ready   | i_in_data  (t_in_word)
//  result   | out       | o_out_valid / i_out_ready | o_out_data (t_out_word)
//  config   | in        | i_cfg_we (no wait)        | i_cfg_wdata (units_in_service)
//
// A request is handled in waves, the second only when it is granted:
// a scan wave runs down the cell row one cell a cycle to release units and
// count free ones, then a fill wave runs down it again to take the lowest ones.
// One request is in work at a time; the next is taken once the result sits in
// the output register. A stalled result holds the block in its final state.
// Reset (synchronous, active low) frees every unit and sets the pool to 64, or to MAX_UNITS if fewer.
module timed_lowest_free_unit_allocator_unit #(
    parameter int unsigned MAX_UNITS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  tlfa_pkg::t_in_word                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output tlfa_pkg::t_out_word                o_out_data,
    input  logic                               i_cfg_we,
    input  logic [tlfa_pkg::COUNT_W-1:0]       i_cfg_wdata
);

    localparam logic [tlfa_pkg::CNT_W-1:0] MAX_U = tlfa_pkg::CNT_W'(MAX_UNITS);
    localparam logic [tlfa_pkg::CNT_W-1:0] RESET_POOL =
        (MAX_UNITS < 64) ? tlfa_pkg::CNT_W'(MAX_UNITS) : tlfa_pkg::CNT_W'(64);

    tlfa_pkg::t_state                  r_state;
    tlfa_pkg::t_state                  n_state;
    logic [tlfa_pkg::CNT_W-1:0]        r_pool;
    logic [tlfa_pkg::CNT_W-1:0]        n_pool;
    logic [tlfa_pkg::TIME_W-1:0]       r_now;
    logic [tlfa_pkg::TIME_W-1:0]       r_rel;
    logic [tlfa_pkg::COUNT_W-1:0]      r_want;
    logic                              r_granted;
    logic [tlfa_pkg::SUM_W-1:0]        r_sum;
    logic                              r_out_valid;
    tlfa_pkg::t_out_word               r_out;
    logic [tlfa_pkg::TIME_W:0]         w_end;
    logic [tlfa_pkg::TIME_W-1:0]       w_rel;
    logic                              w_accept;
    logic                              w_enough;
    logic                              w_load_out;
    tlfa_pkg::t_wave                   w_launch;
    tlfa_pkg::t_wave                   w_wave [0:MAX_UNITS];
    logic [MAX_UNITS-1:0]              w_grant;
    logic [tlfa_pkg::MASK_W-1:0]       w_mask;
    tlfa_pkg::t_wave                   w_last;

    assign w_last     = w_wave[MAX_UNITS];
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_enough   = w_last.cnt >= tlfa_pkg::CNT_W'(r_want);
    assign w_load_out = (r_state == tlfa_pkg::ST_DONE) && (!r_out_valid || i_out_ready);

    // Release time saturates at the top of the time range
    always_comb begin
        w_end = {1'b0, i_in_data.request_time} +
                (tlfa_pkg::TIME_W + 1)'(i_in_data.hold_time);
        w_rel = w_end[tlfa_pkg::TIME_W] ? '1 : w_end[tlfa_pkg::TIME_W-1:0];
    end

    // Clamp the pool to the number of cells
    always_comb begin
        n_pool = (tlfa_pkg::CNT_W'(i_cfg_wdata) < MAX_U) ?
                 tlfa_pkg::CNT_W'(i_cfg_wdata) : MAX_U;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlfa_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = tlfa_pkg::ST_LAUNCH_SCAN;
            end
            tlfa_pkg::ST_LAUNCH_SCAN: begin
                n_state = tlfa_pkg::ST_SCAN;
            end
            tlfa_pkg::ST_SCAN: begin
                if (w_last.scan) begin
                    n_state = w_enough ? tlfa_pkg::ST_LAUNCH_FILL : tlfa_pkg::ST_DONE;
                end
            end
            tlfa_pkg::ST_LAUNCH_FILL: begin
                n_state = tlfa_pkg::ST_FILL;
            end
            tlfa_pkg::ST_FILL: begin
                if (w_last.fill) n_state = tlfa_pkg::ST_DONE;
            end
            tlfa_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = tlfa_pkg::ST_IDLE;
            end
            default: n_state = tlfa_pkg::ST_IDLE;
        endcase
    end

    // State outputs: input ready and the wave fed into the first cell
    always_comb begin
        o_in_ready    = (r_state == tlfa_pkg::ST_IDLE);
        w_launch      = '0;
        w_launch.scan = (r_state == tlfa_pkg::ST_LAUNCH_SCAN);
        w_launch.fill = (r_state == tlfa_pkg::ST_LAUNCH_FILL);
        if (r_state == tlfa_pkg::ST_LAUNCH_FILL) begin
            w_launch.cnt = tlfa_pkg::CNT_W'(r_want);
        end
    end

    assign w_wave[0] = w_launch;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlfa_pkg::ST_IDLE;
            r_pool      <= RESET_POOL;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_pool <= n_pool;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the request, the decision and the result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now  <= i_in_data.request_time;
            r_rel  <= w_rel;
            r_want <= i_in_data.unit_count;
        end
        if (r_state == tlfa_pkg::ST_SCAN && w_last.scan) begin
            r_granted <= w_enough;
            r_sum     <= '0;
        end
        if (r_state == tlfa_pkg::ST_FILL && w_last.fill) begin
            r_sum <= w_last.sum;
        end
        if (w_load_out) begin
            r_out.granted      <= r_granted;
            r_out.id_sum       <= r_sum;
            r_out.granted_mask <= w_mask & {tlfa_pkg::MASK_W{r_granted}};
        end
    end

    // Row of unit cells
    for (genvar g = 0; g < MAX_UNITS; g++) begin : g_cell
        tlfa_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clear    (i_cfg_we),
            .i_in_pool  (tlfa_pkg::CNT_W'(g) < r_pool),
            .i_unit_num (tlfa_pkg::SUM_W'(g + 1)),
            .i_now      (r_now),
            .i_rel_time (r_rel),
            .i_wave     (w_wave[g]),
            .o_wave     (w_wave[g+1]),
            .o_grant    (w_grant[g])
        );
    end

    // Mask covers the first 64 units only
    for (genvar j = 0; j < tlfa_pkg::MASK_W; j++) begin : g_mask
        if (j < MAX_UNITS) begin : g_bit
            assign w_mask[j] = w_grant[j];
        end else begin : g_zero
            assign w_mask[j] = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Free count seen at the end of a scan never exceeds the pool
    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.scan |-> (w_last.cnt <= r_pool))
        else $error("scan counted more free units than the pool holds");

    // A fill wave leaves the row with every wanted unit taken
    a_fill_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.fill |-> (w_last.cnt == '0))
        else $error("fill wave ended with units still wanted");

    // A granted request marks exactly the wanted number of cells
    a_grant_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlfa_pkg::ST_DONE && r_granted) |->
        ($countones(w_grant) == int'(r_want)))
        else $error("granted cell count differs from unit count");

    // A refusal carries no units
    a_refuse_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.granted) |->
        (o_out_data.id_sum == '0 && o_out_data.granted_mask == '0))
        else $error("refused word carries units");

endmodule

/* hdl/tlfa_cell.sv */
// One unit of the pool: busy flag, release time and one stage of the wave.
module tlfa_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_in_pool,
    input  logic [tlfa_pkg::SUM_W-1:0]     i_unit_num,
    input  logic [tlfa_pkg::TIME_W-1:0]    i_now,
    input  logic [tlfa_pkg::TIME_W-1:0]    i_rel_time,
    input  tlfa_pkg::t_wave                i_wave,
    output tlfa_pkg::t_wave                o_wave,
    output logic                           o_grant
);

    logic                          r_busy;
    logic                          n_busy;
    logic [tlfa_pkg::TIME_W-1:0]   r_rel_time;
    logic                          r_grant;
    tlfa_pkg::t_wave               r_wave;
    tlfa_pkg::t_wave               n_wave;
    logic                          w_expired;
    logic                          w_free;
    logic                          w_take;

    // Decide release and take for this unit
    always_comb begin
        w_expired = i_in_pool && r_busy && (r_rel_time <= i_now);
        w_free    = i_in_pool && (!r_busy || w_expired);
        w_take    = i_in_pool && !r_busy && (i_wave.cnt != '0);
    end

    // Update the wave passing through and the busy flag
    always_comb begin
        n_wave = i_wave;
        if (i_wave.scan) begin
            n_wave.cnt = i_wave.cnt + tlfa_pkg::CNT_W'(w_free);
        end else if (i_wave.fill && w_take) begin
            n_wave.cnt = i_wave.cnt - tlfa_pkg::CNT_W'(1);
            n_wave.sum = i_wave.sum + i_unit_num;
        end

        priority if (i_clear) begin
            n_busy = 1'b0;
        end else if (i_wave.scan && w_expired) begin
            n_busy = 1'b0;
        end else if (i_wave.fill && w_take) begin
            n_busy = 1'b1;
        end else begin
            n_busy = r_busy;
        end
    end

    // Hold state and forward the wave
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_grant <= 1'b0;
            r_wave  <= '0;
        end else begin
            r_busy <= n_busy;
            r_wave <= n_wave;
            if (i_wave.fill) begin
                r_grant <= w_take;
            end
        end
    end

    // Store the release time of a granted unit
    always_ff @(posedge i_clk) begin
        if (i_wave.fill && w_take) begin
            r_rel_time <= i_rel_time;
        end
    end

    assign o_wave  = r_wave;
    assign o_grant = r_grant;

endmodule

/* tb/sv/tb_timed_lowest_free_unit_allocator_unit.sv */
// Testbench for the timed lowest-free unit allocator: directed and random requests, checked live.
module tb_timed_lowest_free_unit_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned POOL_LIMIT = 64;
    localparam int unsigned DRAIN_WAIT = 2 * POOL_LIMIT + 10;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    tlfa_pkg::t_in_word           in_data   = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    tlfa_pkg::t_out_word          out_data;
    logic                         cfg_we    = 1'b0;
    logic [tlfa_pkg::COUNT_W-1:0] cfg_wdata = '0;

    // Shadow copy of the pool
    logic                         unit_busy [POOL_LIMIT];
    logic [tlfa_pkg::TIME_W-1:0]  unit_release [POOL_LIMIT];
    int unsigned                  free_units;
    logic [tlfa_pkg::COUNT_W-1:0] pool_reg;

    tlfa_pkg::t_out_word          expected_grants [$];
    int unsigned                  fail_count = 0;
    int unsigned                  burst_left = 0;
    logic [tlfa_pkg::TIME_W-1:0]  now_t = '0;

    timed_lowest_free_unit_allocator_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned active_units();
        return (pool_reg < POOL_LIMIT) ? int'(pool_reg) : POOL_LIMIT;
    endfunction

    // Free every unit and take the pool size from the register
    function automatic void clear_shadow_pool();
        for (int i = 0; i < POOL_LIMIT; i++) begin
            unit_busy[i]    = 1'b0;
            unit_release[i] = '0;
        end
        free_units = active_units();
    endfunction

    // Release expired units, then take the lowest free ones if enough are free
    function automatic tlfa_pkg::t_out_word predict_allocation(tlfa_pkg::t_in_word w);
        tlfa_pkg::t_out_word          r;
        int unsigned                  lim;
        int unsigned                  taken;
        int unsigned                  sum;
        logic [tlfa_pkg::TIME_W:0]    end_t;
        logic [tlfa_pkg::TIME_W-1:0]  rel;
        lim = active_units();
        r   = '0;
        for (int i = 0; i < lim; i++) begin
            if (unit_busy[i] && unit_release[i] <= w.request_time) begin
                unit_busy[i] = 1'b0;
                free_units++;
            end
        end
        if (free_units >= w.unit_count) begin
            end_t = {1'b0, w.request_time} + w.hold_time;
            rel   = end_t[tlfa_pkg::TIME_W] ? '1 : end_t[tlfa_pkg::TIME_W-1:0];
            taken = 0;
            sum   = 0;
            for (int i = 0; i < lim && taken < w.unit_count; i++) begin
                if (!unit_busy[i]) begin
                    unit_busy[i]       = 1'b1;
                    unit_release[i]    = rel;
                    taken++;
                    sum += i + 1;
                    r.granted_mask[i]  = 1'b1;
                end
            end
            free_units -= taken;
            r.granted   = 1'b1;
            r.id_sum    = sum[tlfa_pkg::SUM_W-1:0];
        end
        return r;
    endfunction

    // Send one request word in bursts with random gaps, predict it on acceptance
    task automatic send_request(input logic [tlfa_pkg::TIME_W-1:0] t, input int unsigned cnt,
                                input int unsigned hold);
        int unsigned        gap;
        tlfa_pkg::t_in_word w;
        w.request_time = t;
        w.unit_count   = cnt[tlfa_pkg::COUNT_W-1:0];
        w.hold_time    = hold[tlfa_pkg::HOLD_W-1:0];
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_grants.push_back(predict_allocation(w));
    endtask

    // Hold the sender until every pending result is back
    task automatic wait_drained();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (expected_grants.size() != 0) @(posedge clk);
    endtask

    task automatic write_pool_size(input logic [tlfa_pkg::COUNT_W-1:0] v);
        wait_drained();
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pool_reg   = v;
        clear_shadow_pool();
    endtask

    // Check each result word and advance the receiver stall pattern
    always @(posedge clk) begin
        static int unsigned stall_left = 0;
        static int unsigned stall_pct  = 0;
        static int unsigned mode_cycle = 0;
        tlfa_pkg::t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_grants.size() == 0) begin
                $error("result word with no request pending: %h", out_data);
                fail_count++;
            end else begin
                want = expected_grants.pop_front();
                if (out_data.granted !== want.granted) begin
                    $error("granted: expected %0d, got %0d", want.granted, out_data.granted);
                    fail_count++;
                end
                if (out_data.id_sum !== want.id_sum) begin
                    $error("id_sum: expected %0d, got %0d", want.id_sum, out_data.id_sum);
                    fail_count++;
                end
                if (out_data.granted_mask !== want.granted_mask) begin
                    $error("granted_mask: expected %h, got %h",
                           want.granted_mask, out_data.granted_mask);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 24);
        end
        mode_cycle++;
        if (mode_cycle == 700) begin
            mode_cycle = 0;
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 5;
                2: stall_pct = 30;
                default: stall_pct = 70;
            endcase
        end
    end

    // Corners on the default pool: zero count, full pool, refusals, saturation, going back in time
    task automatic test_reset_pool();
        send_request(32'd0, 0, 1);
        send_request(32'd0, 64, 65535);
        send_request(32'd100, 1, 1);
        send_request(32'd65534, 127, 1);
        send_request(32'd65535, 5, 100);
        send_request(32'd65535, 3, 200);
        send_request(32'd65635, 2, 1);
        send_request(32'd10, 4, 50);
        send_request(32'hFFFF_FFF0, 60, 65535);
        send_request(32'hFFFF_FFFF, 4, 1);
        send_request(32'hFFFF_FFFF, 1, 1);
        send_request(32'hAAAA_AAAA, 64, 16'h5555);
        send_request(32'h5555_5555, 63, 16'hAAAA);
    endtask

    // Empty, single, clamped and oversized pools
    task automatic test_pool_sizes();
        write_pool_size(7'd0);
        send_request(32'd20, 0, 5);
        send_request(32'd20, 1, 5);
        write_pool_size(7'd1);
        send_request(32'd30, 1, 10);
        send_request(32'd35, 1, 10);
        send_request(32'd40, 1, 10);
        write_pool_size(7'd127);
        send_request(32'd50, 64, 3);
        send_request(32'd52, 1, 3);
        write_pool_size(7'd100);
        send_request(32'd60, 65, 1);
    endtask

    // Mostly rising times with small steps so units pile up and expire
    task automatic test_random_traffic(input logic [tlfa_pkg::COUNT_W-1:0] pool,
                                       input int unsigned n);
        int unsigned r;
        int unsigned cnt;
        int unsigned hold;
        int unsigned span;
        write_pool_size(pool);
        span = active_units() / 3;
        if (span < 2) span = 2;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3)       now_t = $urandom();
            else if (r < 5)  now_t = 32'hFFFF_FFFF - $urandom_range(0, 300);
            else             now_t = now_t + $urandom_range(0, 30);
            r = $urandom_range(0, 99);
            if (r < 85)      cnt = $urandom_range(0, span);
            else if (r < 97) cnt = $urandom_range(0, 64);
            else             cnt = $urandom_range(65, 127);
            r = $urandom_range(0, 99);
            if (r < 80)      hold = $urandom_range(1, 120);
            else if (r < 95) hold = $urandom_range(1, 65535);
            else             hold = 65535;
            send_request(now_t, cnt, hold);
            if ($urandom_range(0, 149) == 0) wait_drained();
        end
    endtask

    // Pause the sender until the block is empty, then resume sending in bursts
    task automatic test_drain_pause();
        write_pool_size(7'd64);
        for (int k = 0; k < 10; k++) send_request(now_t + k, $urandom_range(1, 9), 40);
        wait_drained();
        repeat (20) @(posedge clk);
        for (int k = 0; k < 10; k++) send_request(now_t + 20 + k, $urandom_range(1, 9), 40);
        now_t = now_t + 30;
    endtask

    initial begin
        pool_reg = tlfa_pkg::UNITS_RESET;
        clear_shadow_pool();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_pool();
        test_pool_sizes();
        test_drain_pause();
        test_random_traffic(7'd64, 125);
        test_random_traffic(7'd13, 125);
        test_random_traffic(7'd1, 125);
        test_random_traffic(7'd127, 125);
        test_random_traffic(7'd0, 20);
        test_random_traffic(7'd40, 125);
        test_random_traffic(7'd100, 125);
        test_random_traffic(7'd64, 125);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #8ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
hdl/tlfa_pkg.sv
hdl/tlfa_cell.sv
hdl/timed_lowest_free_unit_allocator_unit.sv
tb/sv/tb_timed_lowest_free_unit_allocator_unit.sv
